// File: hw/rtl/kcg_pkg.sv
// ----------------------------------------------------------------------------
// kcg_pkg
// Shared constants and types for the k-combination generator.
// ----------------------------------------------------------------------------
package kcg_pkg;

    localparam int N_MAX  = 64;
    localparam int K_MAX  = 8;
    localparam int POS_W  = $clog2(N_MAX);
    localparam int IDX_W  = $clog2(K_MAX);
    localparam int N_W    = 7;
    localparam int K_W    = 4;
    localparam int MASK_W = 64;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [N_W-1:0] SET_SIZE_RST     = N_W'(4);
    localparam logic [K_W-1:0] CHOOSE_COUNT_RST = K_W'(2);

    typedef enum logic {
        REG_SET_SIZE     = 1'b0,
        REG_CHOOSE_COUNT = 1'b1
    } t_reg_idx;

    typedef logic [POS_W-1:0] t_pos_array [K_MAX];

endpackage

// File: hw/rtl/k_combination_generator.sv
// ----------------------------------------------------------------------------
// k_combination_generator
// Steps through the k-element subsets of 0..n-1 in lexicographic order and
// returns each one as an occupation mask, flagging the last one.
//
//   Channel   Direction   Handshake                   Payload
//   in        sink        i_in_valid / o_in_ready     i_restart
//   out       source      o_out_valid / i_out_ready   o_subset_mask, o_last_subset,
//                                                     o_exhausted
//   cfg       APB slave   psel / penable / pready     paddr, pwdata, prdata
//
// A beat waits in the input register and passes the successor logic into the
// result register once the result stage can advance.
// One beat per cycle is sustained while results are taken; the successor rule reads
// and writes the position registers in the same cycle.
// A stalled result holds the input register, and input stalls only when both
// registers are full and the result is not taken. Reset empties both stages
// and restores the defaults.
// ----------------------------------------------------------------------------
module k_combination_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_restart,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [kcg_pkg::MASK_W-1:0]           o_subset_mask,
    output logic                                 o_last_subset,
    output logic                                 o_exhausted,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kcg_pkg::ADDR_W-1:0]           paddr,
    input  logic [kcg_pkg::DATA_W-1:0]           pwdata,
    output logic [kcg_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    logic [kcg_pkg::N_W-1:0]    r_set_size;
    logic [kcg_pkg::K_W-1:0]    r_choose_count;
    logic                       r_started;
    logic                       r_finished;
    kcg_pkg::t_pos_array        r_pos;
    logic                       r_in_valid;
    logic                       r_restart;
    logic                       r_out_valid;
    logic [kcg_pkg::MASK_W-1:0] r_mask;
    logic                       r_last;
    logic                       r_exh;

    logic                       w_adv;
    logic                       w_fire;
    logic                       w_cfg_wr;
    kcg_pkg::t_reg_idx          w_reg_idx;
    logic [kcg_pkg::N_W-1:0]    w_n;
    logic [kcg_pkg::N_W-1:0]    w_n_minus_k;
    logic                       w_empty;
    logic                       w_do_restart;
    logic [kcg_pkg::K_MAX-1:0]  w_grow;
    logic [kcg_pkg::IDX_W-1:0]  w_sel;
    logic [kcg_pkg::POS_W-1:0]  w_base;
    logic                       n_exh;
    logic                       n_last;
    logic [kcg_pkg::MASK_W-1:0] n_mask;
    kcg_pkg::t_pos_array        n_pos;

    assign pready        = 1'b1;
    assign w_reg_idx     = kcg_pkg::t_reg_idx'(paddr[2]);
    assign w_cfg_wr      = psel && penable && pwrite;
    assign w_adv         = !r_out_valid || i_out_ready;
    assign w_fire        = r_in_valid && w_adv;
    assign o_in_ready    = !r_in_valid || w_adv;
    assign o_out_valid   = r_out_valid;
    assign o_subset_mask = r_mask;
    assign o_last_subset = r_last;
    assign o_exhausted   = r_exh;

    always_comb begin
        unique case (w_reg_idx)
            kcg_pkg::REG_SET_SIZE: begin
                prdata = kcg_pkg::DATA_W'(r_set_size);
            end
            kcg_pkg::REG_CHOOSE_COUNT: begin
                prdata = kcg_pkg::DATA_W'(r_choose_count);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_comb begin
        w_n = (r_set_size > kcg_pkg::N_W'(kcg_pkg::N_MAX)) ?
              kcg_pkg::N_W'(kcg_pkg::N_MAX) : r_set_size;
        w_empty = (w_n == '0) || (r_choose_count == '0) ||
                  (r_choose_count > kcg_pkg::K_W'(kcg_pkg::K_MAX)) ||
                  (kcg_pkg::N_W'(r_choose_count) > w_n);
        w_n_minus_k  = w_n - kcg_pkg::N_W'(r_choose_count);
        w_do_restart = r_restart || !r_started;

        for (int i = 0; i < kcg_pkg::K_MAX; i++) begin
            w_grow[i] = (kcg_pkg::K_W'(i) < r_choose_count) &&
                        (kcg_pkg::N_W'(r_pos[i]) < (w_n_minus_k + kcg_pkg::N_W'(i)));
        end

        w_sel = '0;
        for (int i = 0; i < kcg_pkg::K_MAX; i++) begin
            if (w_grow[i]) begin
                w_sel = kcg_pkg::IDX_W'(i);
            end
        end
        w_base = r_pos[w_sel] + kcg_pkg::POS_W'(1);

        for (int j = 0; j < kcg_pkg::K_MAX; j++) begin
            if (w_do_restart) begin
                n_pos[j] = kcg_pkg::POS_W'(j);
            end else if (kcg_pkg::IDX_W'(j) < w_sel) begin
                n_pos[j] = r_pos[j];
            end else begin
                n_pos[j] = w_base + kcg_pkg::POS_W'(j) - kcg_pkg::POS_W'(w_sel);
            end
        end

        if (w_do_restart) begin
            n_exh = w_empty;
        end else begin
            n_exh = r_finished || w_empty || !(|w_grow);
        end

        n_mask = '0;
        for (int j = 0; j < kcg_pkg::K_MAX; j++) begin
            if (kcg_pkg::K_W'(j) < r_choose_count) begin
                n_mask[n_pos[j]] = 1'b1;
            end
        end
        if (n_exh) begin
            n_mask = '0;
        end
        n_last = !n_exh && (n_pos[0] == w_n_minus_k[kcg_pkg::POS_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size     <= kcg_pkg::SET_SIZE_RST;
            r_choose_count <= kcg_pkg::CHOOSE_COUNT_RST;
            r_started      <= 1'b0;
            r_finished     <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    kcg_pkg::REG_SET_SIZE: begin
                        r_set_size <= pwdata[kcg_pkg::N_W-1:0];
                    end
                    kcg_pkg::REG_CHOOSE_COUNT: begin
                        r_choose_count <= pwdata[kcg_pkg::K_W-1:0];
                    end
                    default: begin
                        r_set_size <= r_set_size;
                    end
                endcase
                r_started  <= 1'b0;
                r_finished <= 1'b0;
            end else if (w_fire) begin
                r_started  <= 1'b1;
                r_finished <= n_exh || n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_restart <= i_restart;
        end
        if (w_fire) begin
            r_mask <= n_mask;
            r_last <= n_last;
            r_exh  <= n_exh;
            if (!n_exh) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

// File: hw/rtl/kcg_checker.sv
// ----------------------------------------------------------------------------
// kcg_port_checks
// Port-level checks for the k-combination generator, bound to the top level.
// ----------------------------------------------------------------------------
module kcg_port_checks (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [kcg_pkg::MASK_W-1:0] o_subset_mask,
    input logic                       o_last_subset,
    input logic                       o_exhausted
);

    // An exhausted beat carries no subset and never claims to be the last one.
    a_exh_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_exhausted) |-> (o_subset_mask == '0) && !o_last_subset)
        else $error("exhausted beat carries a subset");

    // A real subset holds between one and K_MAX members.
    a_subset_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_exhausted) |->
            ($countones(o_subset_mask) >= 1) &&
            ($countones(o_subset_mask) <= kcg_pkg::K_MAX))
        else $error("subset size out of range");

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            o_out_valid && $stable(o_subset_mask) && $stable(o_last_subset) &&
            $stable(o_exhausted))
        else $error("stalled result changed");

    // Reset leaves the result stage empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind k_combination_generator kcg_port_checks u_kcg_port_checks (.*);

// File: verif/kcg_checker.sv
// ----------------------------------------------------------------------------
// kcg_checker
// Watches the request, result and register ports of the k-combination
// generator. Every accepted request beat is run through an independent
// successor-rule model to produce the expected mask and flags. Every result
// beat is compared field by field against the oldest expectation. Register
// writes update the model's copy of n and k, and register reads are checked
// against that copy.
// ----------------------------------------------------------------------------
module kcg_checker
    import kcg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              i_restart,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [MASK_W-1:0] o_subset_mask,
    input  logic              o_last_subset,
    input  logic              o_exhausted,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                o_pending_beats,
    output int                o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              last;
        logic              exhausted;
    } t_subset;

    logic [N_W-1:0] set_size_q;
    logic [K_W-1:0] choose_count_q;
    t_pos_array     cur_pos;
    logic           enum_started;
    logic           enum_done;
    t_subset        expected_subsets[$];
    int             error_total;

    task automatic next_subset(input logic restart, output t_subset res);
        int   n;
        int   k;
        int   i;
        int   j;
        logic empty;
        res   = '0;
        n     = (set_size_q > N_MAX) ? N_MAX : int'(set_size_q);
        k     = int'(choose_count_q);
        empty = (n == 0) || (k == 0) || (k > K_MAX) || (k > n);
        if (restart || !enum_started) begin
            enum_started = 1'b1;
            enum_done    = 1'b0;
            if (empty) begin
                enum_done     = 1'b1;
                res.exhausted = 1'b1;
                return;
            end
            for (i = 0; i < k; i++) begin
                cur_pos[i] = POS_W'(i);
            end
        end else begin
            if (enum_done || empty) begin
                enum_done     = 1'b1;
                res.exhausted = 1'b1;
                return;
            end
            // Find the rightmost position that still has room to grow.
            i = k;
            while (i > 0 && int'(cur_pos[i-1]) >= n - k + i - 1) begin
                i--;
            end
            if (i == 0) begin
                enum_done     = 1'b1;
                res.exhausted = 1'b1;
                return;
            end
            i--;
            cur_pos[i] = cur_pos[i] + 1'b1;
            for (j = i + 1; j < k; j++) begin
                cur_pos[j] = cur_pos[j-1] + 1'b1;
            end
        end
        for (i = 0; i < k; i++) begin
            res.mask[cur_pos[i]] = 1'b1;
        end
        if (int'(cur_pos[0]) == n - k) begin
            res.last  = 1'b1;
            enum_done = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_subset           res;
        t_subset           want;
        logic [DATA_W-1:0] reg_value;
        if (!i_rst_n) begin
            set_size_q     = SET_SIZE_RST;
            choose_count_q = CHOOSE_COUNT_RST;
            enum_started   = 1'b0;
            enum_done      = 1'b0;
            for (int i = 0; i < K_MAX; i++) begin
                cur_pos[i] = '0;
            end
            expected_subsets.delete();
        end else begin
            if (psel && penable && pready && paddr[1:0] == 2'b00) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[2]))
                        REG_SET_SIZE:     set_size_q     = pwdata[N_W-1:0];
                        REG_CHOOSE_COUNT: choose_count_q = pwdata[K_W-1:0];
                    endcase
                    enum_started = 1'b0;
                    enum_done    = 1'b0;
                end else begin
                    case (t_reg_idx'(paddr[2]))
                        REG_SET_SIZE:     reg_value = DATA_W'(set_size_q);
                        REG_CHOOSE_COUNT: reg_value = DATA_W'(choose_count_q);
                    endcase
                    if (prdata !== reg_value) begin
                        $error("prdata: expected %h, actual %h", reg_value, prdata);
                        error_total++;
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_subsets.size() == 0) begin
                    $error("result beat with no request outstanding: mask %h",
                           o_subset_mask);
                    error_total++;
                end else begin
                    want = expected_subsets.pop_front();
                    if (o_subset_mask !== want.mask) begin
                        $error("subset_mask: expected %h, actual %h",
                               want.mask, o_subset_mask);
                        error_total++;
                    end
                    if (o_last_subset !== want.last) begin
                        $error("last_subset: expected %b, actual %b",
                               want.last, o_last_subset);
                        error_total++;
                    end
                    if (o_exhausted !== want.exhausted) begin
                        $error("exhausted: expected %b, actual %b",
                               want.exhausted, o_exhausted);
                        error_total++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                next_subset(i_restart, res);
                expected_subsets.insert(expected_subsets.size(), res);
            end
        end
        o_pending_beats <= expected_subsets.size();
        o_error_count   <= error_total;
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the k-combination generator through a directed pass over the reset
// setting and the empty, saturated and single-subset cases, then through
// random phases with fresh set sizes and subset sizes. Both handshake sides
// idle in random bursts, and the result side holds off once long enough to
// back up the pipeline. The checker module predicts and compares every beat.
// ----------------------------------------------------------------------------
module testbench;
    import kcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1900;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic              i_restart     = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic [MASK_W-1:0] o_subset_mask;
    logic              o_last_subset;
    logic              o_exhausted;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending_beats;
    int error_count;
    int cycle_count = 0;
    int beats_sent  = 0;
    bit quiet_tail  = 1'b0;
    bit hold_req    = 1'b0;
    int cur_n       = 4;
    int cur_k       = 2;

    k_combination_generator u_top (.*);

    kcg_checker u_checker (
        .o_pending_beats (pending_beats),
        .o_error_count   (error_count),
        .*
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random ready bursts, one long hold-off, none in the tail.
    initial begin
        repeat (4) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet_tail) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic restart, input bit allow_gap);
        if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic apb_cycle(input logic wr, input t_reg_idx r, input logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only once every outstanding beat has come back.
    task automatic set_config(input int n, input int k, input bit write_n, input bit write_k);
        logic [DATA_W-1:0] word;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (4) @(posedge i_clk);
        if (write_n) begin
            word  = $urandom();
            word  = ((word >> N_W) << N_W) | DATA_W'(n);
            apb_cycle(1'b1, REG_SET_SIZE, word);
            cur_n = n;
        end
        if (write_k) begin
            word  = $urandom();
            word  = ((word >> K_W) << K_W) | DATA_W'(k);
            apb_cycle(1'b1, REG_CHOOSE_COUNT, word);
            cur_k = k;
        end
        apb_cycle(1'b0, REG_SET_SIZE, DATA_W'($urandom()));
        apb_cycle(1'b0, REG_CHOOSE_COUNT, DATA_W'($urandom()));
    endtask

    initial begin
        int n;
        int k;
        int beats;
        int pick;
        bit gaps;
        bit first_phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: n = 4, k = 2, six subsets, then exhausted, then restart.
        for (int i = 0; i < 8; i++) begin
            send_beat(1'b0, 1'b0);
        end
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b0);
        set_config(0, 0, 1'b1, 1'b0);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b0);
        set_config(127, 8, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b0);
        set_config(0, 0, 1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        set_config(0, 15, 1'b0, 1'b1);
        send_beat(1'b1, 1'b0);
        set_config(3, 5, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        set_config(1, 1, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b0);
        set_config(8, 8, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b0);

        beats_sent  = 0;
        first_phase = 1'b1;
        while (beats_sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                n = $urandom_range(0, 127);
                k = $urandom_range(0, 15);
            end else if (pick == 1) begin
                n = $urandom_range(20, 64);
                k = $urandom_range(1, 2);
            end else begin
                n = $urandom_range(1, 9);
                k = $urandom_range(1, (n < K_MAX) ? n : K_MAX);
            end
            case ($urandom_range(0, 5))
                0:       set_config(n, cur_k, 1'b1, 1'b0);
                1:       set_config(cur_n, k, 1'b0, 1'b1);
                default: set_config(n, k, 1'b1, 1'b1);
            endcase
            if (first_phase) begin
                hold_req    = 1'b1;
                first_phase = 1'b0;
            end
            beats = $urandom_range(10, 120);
            gaps  = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < beats; i++) begin
                if (beats_sent >= RANDOM_BEATS - QUIET_TAIL) begin
                    quiet_tail = 1'b1;
                end
                send_beat($urandom_range(0, 24) == 0, gaps);
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/kcg_pkg.sv
hw/rtl/k_combination_generator.sv
hw/rtl/kcg_checker.sv
verif/kcg_checker.sv
verif/testbench.sv
